// File: src/sle_pkg.sv
// ============================================================================
// sle_pkg
// Operation and status codes shared by the sorted list engine.
// ============================================================================
package sle_pkg;

   typedef enum logic [1:0] {
      OP_INSERT  = 2'd0,
      OP_DELETE  = 2'd1,
      OP_REVERSE = 2'd2,
      OP_READ    = 2'd3
   } op_type;

   typedef enum logic [2:0] {
      ST_INSERTED  = 3'd0,
      ST_DELETED   = 3'd1,
      ST_NOT_FOUND = 3'd2,
      ST_EMPTY     = 3'd3,
      ST_FULL      = 3'd4,
      ST_REVERSED  = 3'd5,
      ST_ENTRY     = 3'd6
   } status_type;

   localparam int unsigned DATA_W = 32;

endpackage

// File: src/sorted_list_engine_unit.sv
// ============================================================================
// sorted_list_engine_unit
// Ordered list of signed 32-bit values held in a single-port-read RAM.
// ============================================================================
// The list lives in one RAM with one write port and one registered read port,
// so every visited entry is first read and then evaluated and written back.
// An insert walks to its slot and shifts the tail up, a delete finds the value
// and shifts the tail down, a reverse swaps pairs from both ends inward, and a
// read-out emits one word per entry, held back by any stall on the result side.
// An insert into a full table, or a delete, reverse or read-out on an empty
// list, finishes without touching the RAM. One request word is worked on at a
// time; the next one is taken as soon as the engine is back in its idle state,
// even while the final result word still waits in the output register.
module sorted_list_engine_unit #(
   parameter int DEPTH = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [1:0]         req_op,
   input  logic signed [31:0] req_value,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [2:0]         rsp_status,
   output logic signed [31:0] rsp_entry_value,
   output logic               rsp_last
);
   import sle_pkg::*;

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   typedef enum logic [3:0] {
      S_IDLE,
      S_INS_RD,
      S_INS_EV,
      S_SH_RD,
      S_SH_EV,
      S_DEL_RD,
      S_DEL_EV,
      S_DS_RD,
      S_DS_EV,
      S_REV_LO_RD,
      S_REV_HI_RD,
      S_REV_WR_LO,
      S_REV_WR_HI,
      S_OUT_RD,
      S_OUT_EV,
      S_DONE
   } state_type;

   state_type          state_ff, state_in;
   logic [CW-1:0]      count_ff, count_in;
   logic [CW-1:0]      idx_ff, idx_in;
   logic [CW-1:0]      hi_ff, hi_in;
   logic [CW-1:0]      idx_nx;
   logic [DATA_W-1:0]  carry_ff, carry_in;
   logic signed [31:0] val_ff, val_in;
   status_type         res_status_ff, res_status_in;
   logic [DATA_W-1:0]  res_value_ff, res_value_in;
   logic               rsp_valid_ff, rsp_valid_in;
   status_type         rsp_status_ff, rsp_status_in;
   logic [DATA_W-1:0]  rsp_value_ff, rsp_value_in;
   logic               rsp_last_ff, rsp_last_in;

   logic               wr_en;
   logic [AW-1:0]      wr_addr;
   logic [DATA_W-1:0]  wr_data;
   logic               rd_en;
   logic [AW-1:0]      rd_addr;
   logic [DATA_W-1:0]  rd_data;
   logic               out_free;
   logic               stop;

   sle_ram #(
      .WIDTH (DATA_W),
      .DEPTH (DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign req_ready       = (state_ff == S_IDLE);
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_entry_value = rsp_value_ff;
   assign rsp_last        = rsp_last_ff;

   assign out_free = !rsp_valid_ff || rsp_ready;
   assign idx_nx   = idx_ff + CW'(1);
   assign stop     = (idx_ff == '0) ? (val_ff < $signed(rd_data))
                                    : !($signed(rd_data) < val_ff);

   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      idx_in        = idx_ff;
      hi_in         = hi_ff;
      carry_in      = carry_ff;
      val_in        = val_ff;
      res_status_in = res_status_ff;
      res_value_in  = res_value_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_status_in = rsp_status_ff;
      rsp_value_in  = rsp_value_ff;
      rsp_last_in   = rsp_last_ff;
      wr_en         = 1'b0;
      wr_addr       = idx_ff[AW-1:0];
      wr_data       = carry_ff;
      rd_en         = 1'b0;
      rd_addr       = idx_ff[AW-1:0];

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               val_in       = req_value;
               idx_in       = '0;
               res_value_in = '0;
               unique case (op_type'(req_op))
                  OP_INSERT: begin
                     if (count_ff == CW'(DEPTH)) begin
                        res_status_in = ST_FULL;
                        state_in      = S_DONE;
                     end else if (count_ff == '0) begin
                        carry_in = req_value;
                        state_in = S_SH_RD;
                     end else begin
                        state_in = S_INS_RD;
                     end
                  end
                  OP_DELETE: begin
                     if (count_ff == '0) begin
                        res_status_in = ST_EMPTY;
                        state_in      = S_DONE;
                     end else begin
                        state_in = S_DEL_RD;
                     end
                  end
                  OP_REVERSE: begin
                     hi_in         = count_ff - CW'(1);
                     res_status_in = ST_REVERSED;
                     if (count_ff <= CW'(1)) begin
                        state_in = S_DONE;
                     end else begin
                        state_in = S_REV_LO_RD;
                     end
                  end
                  OP_READ: begin
                     if (count_ff == '0) begin
                        res_status_in = ST_EMPTY;
                        state_in      = S_DONE;
                     end else begin
                        state_in = S_OUT_RD;
                     end
                  end
                  default: state_in = S_IDLE;
               endcase
            end
         end
         S_INS_RD: begin
            rd_en    = 1'b1;
            state_in = S_INS_EV;
         end
         S_INS_EV: begin
            idx_in = idx_nx;
            if (stop) begin
               wr_en    = 1'b1;
               wr_data  = val_ff;
               carry_in = rd_data;
               state_in = S_SH_RD;
            end else if (idx_nx == count_ff) begin
               carry_in = val_ff;
               state_in = S_SH_RD;
            end else begin
               state_in = S_INS_RD;
            end
         end
         S_SH_RD: begin
            if (idx_ff == count_ff) begin
               wr_en         = 1'b1;
               count_in      = count_ff + CW'(1);
               res_status_in = ST_INSERTED;
               state_in      = S_DONE;
            end else begin
               rd_en    = 1'b1;
               state_in = S_SH_EV;
            end
         end
         S_SH_EV: begin
            wr_en    = 1'b1;
            carry_in = rd_data;
            idx_in   = idx_nx;
            state_in = S_SH_RD;
         end
         S_DEL_RD: begin
            rd_en    = 1'b1;
            state_in = S_DEL_EV;
         end
         S_DEL_EV: begin
            if (rd_data == val_ff) begin
               state_in = S_DS_RD;
            end else if (idx_nx == count_ff) begin
               res_status_in = ST_NOT_FOUND;
               state_in      = S_DONE;
            end else begin
               idx_in   = idx_nx;
               state_in = S_DEL_RD;
            end
         end
         S_DS_RD: begin
            if (idx_nx == count_ff) begin
               count_in      = count_ff - CW'(1);
               res_status_in = ST_DELETED;
               res_value_in  = val_ff;
               state_in      = S_DONE;
            end else begin
               rd_en    = 1'b1;
               rd_addr  = idx_nx[AW-1:0];
               state_in = S_DS_EV;
            end
         end
         S_DS_EV: begin
            wr_en    = 1'b1;
            wr_data  = rd_data;
            idx_in   = idx_nx;
            state_in = S_DS_RD;
         end
         S_REV_LO_RD: begin
            rd_en    = 1'b1;
            state_in = S_REV_HI_RD;
         end
         S_REV_HI_RD: begin
            carry_in = rd_data;
            rd_en    = 1'b1;
            rd_addr  = hi_ff[AW-1:0];
            state_in = S_REV_WR_LO;
         end
         S_REV_WR_LO: begin
            wr_en    = 1'b1;
            wr_data  = rd_data;
            state_in = S_REV_WR_HI;
         end
         S_REV_WR_HI: begin
            wr_en   = 1'b1;
            wr_addr = hi_ff[AW-1:0];
            idx_in  = idx_nx;
            hi_in   = hi_ff - CW'(1);
            if (hi_ff > idx_ff + CW'(2)) begin
               state_in = S_REV_LO_RD;
            end else begin
               state_in = S_DONE;
            end
         end
         S_OUT_RD: begin
            rd_en    = 1'b1;
            state_in = S_OUT_EV;
         end
         S_OUT_EV: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = ST_ENTRY;
               rsp_value_in  = rd_data;
               rsp_last_in   = (idx_nx == count_ff);
               if (idx_nx == count_ff) begin
                  state_in = S_IDLE;
               end else begin
                  idx_in   = idx_nx;
                  state_in = S_OUT_RD;
               end
            end
         end
         S_DONE: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_value_in  = res_value_ff;
               rsp_last_in   = 1'b1;
               state_in      = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      idx_ff        <= idx_in;
      hi_ff         <= hi_in;
      carry_ff      <= carry_in;
      val_ff        <= val_in;
      res_status_ff <= res_status_in;
      res_value_ff  <= res_value_in;
      rsp_status_ff <= rsp_status_in;
      rsp_value_ff  <= rsp_value_in;
      rsp_last_ff   <= rsp_last_in;
   end

endmodule

// File: src/sle_ram.sv
// ============================================================================
// sle_ram
// Generic single-write, single-read RAM with a registered read port.
// ============================================================================
module sle_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  logic                                  clock,
   input  logic                                  wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                      wr_data,
   input  logic                                  rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                      rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
